>>> hdl/ssi_pkg.sv
// ----------------------------------------------------------------------------
// ssi_pkg
// shared widths and stage payload types of the sphere-sphere intersect core
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int unsigned COORD_W  = 32;            // signed center coordinate
  localparam int unsigned RAD_W    = 31;            // unsigned radius
  localparam int unsigned DIFF_W   = 32;            // |a - b| of two coordinates
  localparam int unsigned SQ_W     = 2 * DIFF_W;    // one squared axis distance
  localparam int unsigned SUM_W    = SQ_W + 2;      // sum of three squares
  localparam int unsigned ROOT_W   = 34;            // floor square root bits
  localparam int unsigned RADIC_W  = 2 * ROOT_W;    // radicand as fed to the root
  localparam int unsigned REM_W    = ROOT_W + 2;    // partial remainder
  localparam int unsigned RSUM_W   = RAD_W + 1;     // radius sum
  localparam int unsigned SEP_W    = 32;            // saturated separation
  localparam int unsigned XSEP_W   = ROOT_W + 2;    // exact signed separation

  localparam int unsigned S_TDATA_W = 256;
  localparam int unsigned M_TDATA_W = 40;

  // one accepted pair
  typedef struct packed {
    logic                      kind;
    logic signed [COORD_W-1:0] self_x;
    logic signed [COORD_W-1:0] self_y;
    logic signed [COORD_W-1:0] self_z;
    logic        [RAD_W-1:0]   self_r;
    logic signed [COORD_W-1:0] other_x;
    logic signed [COORD_W-1:0] other_y;
    logic signed [COORD_W-1:0] other_z;
    logic        [RAD_W-1:0]   other_r;
  } ssi_item_t;

  // squared distance ready for the root
  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [RSUM_W-1:0] rsum;
    logic              kind;
  } ssi_dist_t;

  // one digit step of the square root
  typedef struct packed {
    logic [RADIC_W-1:0] radic;
    logic [REM_W-1:0]   rem;
    logic [ROOT_W-1:0]  root;
    logic [RSUM_W-1:0]  rsum;
    logic               kind;
  } ssi_root_t;

  // finished root with the radius sum
  typedef struct packed {
    logic [ROOT_W-1:0] distance;
    logic [RSUM_W-1:0] rsum;
    logic              kind;
  } ssi_cmp_t;

  // one result beat
  typedef struct packed {
    logic                    saturated;
    logic signed [SEP_W-1:0] separation;
    logic                    hit;
  } ssi_result_t;

endpackage

>>> hdl/ssi_prep.sv
// ----------------------------------------------------------------------------
// ssi_prep
// axis differences, squares and their sum over three register stages
// ----------------------------------------------------------------------------
module ssi_prep (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  ssi_pkg::ssi_item_t item_i,
  output logic               valid_o,
  output ssi_pkg::ssi_dist_t dist_o
);

  function automatic logic [ssi_pkg::DIFF_W-1:0] abs_diff(
    input logic signed [ssi_pkg::COORD_W-1:0] a,
    input logic signed [ssi_pkg::COORD_W-1:0] b
  );
    logic signed [ssi_pkg::COORD_W:0] d;
    logic        [ssi_pkg::COORD_W:0] m;
    d = {a[ssi_pkg::COORD_W-1], a} - {b[ssi_pkg::COORD_W-1], b};
    m = d[ssi_pkg::COORD_W] ? (~d + 1'b1) : d;
    return m[ssi_pkg::DIFF_W-1:0];
  endfunction

  logic [2:0] v_q;

  // stage 1: magnitudes of the axis differences, radius sum
  logic [ssi_pkg::DIFF_W-1:0] dx_q, dy_q, dz_q;
  logic [ssi_pkg::RSUM_W-1:0] rsum1_q;
  logic                       kind1_q;

  // stage 2: squares
  logic [ssi_pkg::SQ_W-1:0]   sqx_q, sqy_q, sqz_q;
  logic [ssi_pkg::RSUM_W-1:0] rsum2_q;
  logic                       kind2_q;

  // stage 3: sum of squares
  logic [ssi_pkg::SUM_W-1:0]  sum_q;
  logic [ssi_pkg::RSUM_W-1:0] rsum3_q;
  logic                       kind3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q    <= abs_diff(item_i.other_x, item_i.self_x);
      dy_q    <= abs_diff(item_i.other_y, item_i.self_y);
      dz_q    <= abs_diff(item_i.other_z, item_i.self_z);
      rsum1_q <= {1'b0, item_i.self_r} + {1'b0, item_i.other_r};
      kind1_q <= item_i.kind;

      sqx_q   <= dx_q * dx_q;
      sqy_q   <= dy_q * dy_q;
      sqz_q   <= dz_q * dz_q;
      rsum2_q <= rsum1_q;
      kind2_q <= kind1_q;

      sum_q   <= {2'b00, sqx_q} + {2'b00, sqy_q} + {2'b00, sqz_q};
      rsum3_q <= rsum2_q;
      kind3_q <= kind2_q;
    end
  end

  assign valid_o     = v_q[2];
  assign dist_o.sum  = sum_q;
  assign dist_o.rsum = rsum3_q;
  assign dist_o.kind = kind3_q;

endmodule

>>> hdl/ssi_sqrt.sv
// ----------------------------------------------------------------------------
// ssi_sqrt
// pipelined restoring square root, one root bit per register stage
// ----------------------------------------------------------------------------
module ssi_sqrt (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  ssi_pkg::ssi_dist_t dist_i,
  output logic               valid_o,
  output ssi_pkg::ssi_cmp_t  cmp_o
);

  localparam int unsigned N = ssi_pkg::ROOT_W;

  ssi_pkg::ssi_root_t   cur_s [N];
  ssi_pkg::ssi_root_t   stg_q [N];
  logic [N-1:0]         vld_q;

  assign cur_s[0].radic = {{(ssi_pkg::RADIC_W - ssi_pkg::SUM_W){1'b0}}, dist_i.sum};
  assign cur_s[0].rem   = '0;
  assign cur_s[0].root  = '0;
  assign cur_s[0].rsum  = dist_i.rsum;
  assign cur_s[0].kind  = dist_i.kind;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[N-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < N; k++) begin : g_step
    logic [ssi_pkg::REM_W+1:0] rem_sh;
    logic [ssi_pkg::REM_W+1:0] trial;
    logic [ssi_pkg::REM_W+1:0] diff;
    logic                      take;

    if (k > 0) begin : g_link
      assign cur_s[k] = stg_q[k-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign rem_sh = {cur_s[k].rem, cur_s[k].radic[ssi_pkg::RADIC_W-1 -: 2]};
    assign trial  = {{(ssi_pkg::REM_W - ssi_pkg::ROOT_W){1'b0}}, cur_s[k].root, 2'b01};
    assign take   = (rem_sh >= trial);
    assign diff   = take ? (rem_sh - trial) : rem_sh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[k].radic <= {cur_s[k].radic[ssi_pkg::RADIC_W-3:0], 2'b00};
        stg_q[k].rem   <= diff[ssi_pkg::REM_W-1:0];
        stg_q[k].root  <= {cur_s[k].root[ssi_pkg::ROOT_W-2:0], take};
        stg_q[k].rsum  <= cur_s[k].rsum;
        stg_q[k].kind  <= cur_s[k].kind;
      end
    end
  end

  assign valid_o        = vld_q[N-1];
  assign cmp_o.distance = stg_q[N-1].root;
  assign cmp_o.rsum     = stg_q[N-1].rsum;
  assign cmp_o.kind     = stg_q[N-1].kind;

endmodule

>>> hdl/ssi_post.sv
// ----------------------------------------------------------------------------
// ssi_post
// separation, saturation and hit decision, one register stage
// ----------------------------------------------------------------------------
module ssi_post (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  ssi_pkg::ssi_cmp_t    cmp_i,
  output logic                 valid_o,
  output ssi_pkg::ssi_result_t res_o
);

  localparam int unsigned TOP_W = ssi_pkg::XSEP_W - ssi_pkg::SEP_W + 1;

  logic signed [ssi_pkg::XSEP_W-1:0] xsep;
  logic [TOP_W-1:0]                  top;
  logic                              neg, sat_hi, sat_lo;
  ssi_pkg::ssi_result_t              res_d, res_q;
  logic                              valid_q;

  assign xsep   = {2'b00, cmp_i.distance}
                - {{(ssi_pkg::XSEP_W - ssi_pkg::RSUM_W){1'b0}}, cmp_i.rsum};
  assign top    = xsep[ssi_pkg::XSEP_W-1 -: TOP_W];
  assign neg    = xsep[ssi_pkg::XSEP_W-1];
  assign sat_hi = !neg && (top != '0);
  assign sat_lo = neg && (top != '1);

  always_comb begin
    res_d = '0;
    if (!cmp_i.kind) begin
      res_d.hit       = neg;
      res_d.saturated = sat_hi || sat_lo;
      if (sat_hi) begin
        res_d.separation = {1'b0, {(ssi_pkg::SEP_W-1){1'b1}}};
      end else if (sat_lo) begin
        res_d.separation = {1'b1, {(ssi_pkg::SEP_W-1){1'b0}}};
      end else begin
        res_d.separation = xsep[ssi_pkg::SEP_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> hdl/sphere_sphere_intersect_core.sv
// ----------------------------------------------------------------------------
// sphere_sphere_intersect_core
// streaming sphere-sphere intersection test with a pipelined square root
// ----------------------------------------------------------------------------
// Takes one sphere pair per beat and returns one result beat per pair, in
// order. The center distance is the exact floor square root of the summed
// squared axis differences (Q32.32 in, Q16.16 out); hit is set when that
// distance is strictly below the radius sum, and separation is distance
// minus radius sum, clamped to 32 bits signed with saturated flagging the
// clamp. An unsupported pair (tuser bit 0 set) yields all-zero result
// fields. Throughput is one pair per clock cycle while the skid register
// is free. Between an accepted input beat and the master side lie three
// stages for differences, squares and sum, 34 stages of the square root
// (one root bit per stage), and one stage for separation and saturation.
// A two-entry output (result register plus skid register) lets the
// pipeline keep accepting while a result waits; s_axis_tready drops only
// while the skid register is occupied.
// ----------------------------------------------------------------------------
module sphere_sphere_intersect_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,

  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // self_center_x [31:0], self_center_y [63:32], self_center_z [95:64],
  // self_radius [126:96], other_center_x [158:127], other_center_y [190:159],
  // other_center_z [222:191], other_radius [253:223], zero [255:254]
  input  logic [ssi_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // pair_kind [0]
  input  logic                             s_axis_tuser,

  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // hit [0], separation [32:1], saturated [33], zero [39:34]
  output logic [ssi_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

  // unpack the input beat
  ssi_pkg::ssi_item_t   item;
  ssi_pkg::ssi_dist_t   sq_dist;
  ssi_pkg::ssi_cmp_t    cmp;
  ssi_pkg::ssi_result_t res, skid_q, out_res;

  logic en;
  logic prep_valid, sqrt_valid, post_valid;
  logic skid_valid_q, skid_valid_d;

  assign item.kind    = s_axis_tuser;
  assign item.self_x  = s_axis_tdata[31:0];
  assign item.self_y  = s_axis_tdata[63:32];
  assign item.self_z  = s_axis_tdata[95:64];
  assign item.self_r  = s_axis_tdata[126:96];
  assign item.other_x = s_axis_tdata[158:127];
  assign item.other_y = s_axis_tdata[190:159];
  assign item.other_z = s_axis_tdata[222:191];
  assign item.other_r = s_axis_tdata[253:223];

  // whole pipeline advances while the skid register is free
  assign en            = !skid_valid_q;
  assign s_axis_tready = en;

  ssi_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .item_i  (item),
    .valid_o (prep_valid),
    .dist_o  (sq_dist)
  );

  ssi_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (prep_valid),
    .dist_i  (sq_dist),
    .valid_o (sqrt_valid),
    .cmp_o   (cmp)
  );

  ssi_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sqrt_valid),
    .cmp_i   (cmp),
    .valid_o (post_valid),
    .res_o   (res)
  );

  // skid: catch a result that was not taken while the pipeline moved on
  always_comb begin
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (m_axis_tready) begin
        skid_valid_d = 1'b0;
      end
    end else if (post_valid && !m_axis_tready) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_valid_q <= 1'b0;
    end else begin
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_valid_q) begin
      skid_q <= res;
    end
  end

  assign out_res       = skid_valid_q ? skid_q : res;
  assign m_axis_tvalid = skid_valid_q || post_valid;
  assign m_axis_tdata  = {{(ssi_pkg::M_TDATA_W - ssi_pkg::SEP_W - 2){1'b0}},
                          out_res.saturated, out_res.separation, out_res.hit};

endmodule

>>> tb/tb_sphere_sphere_intersect_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sphere_sphere_intersect_core
// self-checking bench for the streaming sphere-sphere intersection core
// ----------------------------------------------------------------------------
// A directed table opens the run with field extremes, the unsupported pair,
// exact touching, saturation on both sides and both clamp boundaries. Rows
// whose verdict is obvious carry it typed in; the rest, and about two
// thousand random pairs after them, are checked against a local contact
// predictor (exact squared distance, floor root, radius sum, clamp). Both
// stream sides idle in short random bursts, the result side holds off once
// for a long stretch so the pipeline fills and backs up, and the tail of
// the run streams without gaps.
// ----------------------------------------------------------------------------
module tb_sphere_sphere_intersect_core;

  localparam logic KIND_SPHERES     = 1'b0;
  localparam logic KIND_UNSUPPORTED = 1'b1;

  localparam int unsigned RANDOM_PAIRS     = 2000;
  localparam int unsigned CALM_TAIL        = 200;  // last pairs without any idling
  localparam int unsigned LONG_HOLD_AFTER  = 600;  // results before the long hold-off
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned DRAIN_CYCLES     = 60;   // past the pipeline latency

  // one sphere pair as carried on the input stream
  typedef struct packed {
    logic              kind;
    logic signed [31:0] self_x;
    logic signed [31:0] self_y;
    logic signed [31:0] self_z;
    logic        [30:0] self_r;
    logic signed [31:0] other_x;
    logic signed [31:0] other_y;
    logic signed [31:0] other_z;
    logic        [30:0] other_r;
  } sphere_pair_t;

  // verdict for one pair
  typedef struct packed {
    logic               hit;
    logic signed [31:0] sep;
    logic               sat;
  } contact_t;

  typedef struct packed {
    sphere_pair_t pair;
    logic         typed;  // verdict written in the row, not predicted
    contact_t     want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                              s_axis_tvalid;
  logic                              s_axis_tready;
  logic [ssi_pkg::S_TDATA_W-1:0]     s_axis_tdata;
  logic                              s_axis_tuser;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready;
  logic [ssi_pkg::M_TDATA_W-1:0]     m_axis_tdata;

  contact_t    contact_q[$];   // verdicts of accepted pairs, oldest first
  stim_row_t   directed_rows[$];
  int unsigned errors = 0;
  int unsigned results_seen = 0;
  bit          calm = 1'b0;    // no idling on either side
  bit          long_hold_done = 1'b0;

  sphere_sphere_intersect_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // magnitude of one axis difference, exact in 32 bits
  function automatic logic [31:0] axis_gap(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [32:0] d;
    d = $signed({a[31], a}) - $signed({b[31], b});
    if (d < 0) d = -d;
    return d[31:0];
  endfunction

  function automatic contact_t predict_contact(sphere_pair_t p);
    logic [31:0]        gx, gy, gz;
    logic [67:0]        sq_sum;
    logic [67:0]        trial_sq;
    logic [33:0]        distance;
    logic [33:0]        trial;
    logic [32:0]        rsum;
    logic signed [35:0] gap;
    contact_t           c;
    c = '0;
    if (p.kind == KIND_UNSUPPORTED) return c;
    gx = axis_gap(p.other_x, p.self_x);
    gy = axis_gap(p.other_y, p.self_y);
    gz = axis_gap(p.other_z, p.self_z);
    sq_sum = 68'(gx) * 68'(gx) + 68'(gy) * 68'(gy) + 68'(gz) * 68'(gz);
    // floor root, one bit at a time from the top
    distance = '0;
    for (int i = 33; i >= 0; i--) begin
      trial = distance | (34'd1 << i);
      trial_sq = 68'(trial) * 68'(trial);
      if (trial_sq <= sq_sum) distance = trial;
    end
    rsum = 33'(p.self_r) + 33'(p.other_r);
    gap = $signed(36'(distance)) - $signed(36'(rsum));
    c.hit = (36'(distance) < 36'(rsum));
    if (gap > 36'sd2147483647) begin
      c.sep = 32'h7FFF_FFFF;
      c.sat = 1'b1;
    end else if (gap < -36'sd2147483648) begin
      c.sep = 32'h8000_0000;
      c.sat = 1'b1;
    end else begin
      c.sep = gap[31:0];
    end
    return c;
  endfunction

  function automatic sphere_pair_t make_pair(logic kind,
      logic [31:0] sx, logic [31:0] sy, logic [31:0] sz, logic [30:0] s_rad,
      logic [31:0] ox, logic [31:0] oy, logic [31:0] oz, logic [30:0] o_rad);
    sphere_pair_t p;
    p.kind    = kind;
    p.self_x  = sx;
    p.self_y  = sy;
    p.self_z  = sz;
    p.self_r  = s_rad;
    p.other_x = ox;
    p.other_y = oy;
    p.other_z = oz;
    p.other_r = o_rad;
    return p;
  endfunction

  task automatic add_row(input sphere_pair_t p, input logic typed, input logic hit,
                         input logic [31:0] sep, input logic sat);
    stim_row_t row;
    row.pair     = p;
    row.typed    = typed;
    row.want.hit = hit;
    row.want.sep = sep;
    row.want.sat = sat;
    directed_rows.push_back(row);
  endtask

  // offer one pair, with an optional idle burst ahead of it, and record its verdict
  task automatic send_pair(input sphere_pair_t p, input logic typed, input contact_t want);
    int unsigned idle_len;
    if (!calm && $urandom_range(0, 5) == 0) begin
      idle_len = $urandom_range(1, 3);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (idle_len - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= p.kind;
    s_axis_tdata  <= {2'b00, p.other_r, p.other_z, p.other_y, p.other_x,
                      p.self_r, p.self_z, p.self_y, p.self_x};
    do @(posedge clk_i); while (!s_axis_tready);
    contact_q.push_back(typed ? want : predict_contact(p));
  endtask

  // result side: short random stalls, one long hold-off once the run is going
  initial begin : result_sink
    int unsigned hold_len;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!rst_ni) begin
        m_axis_tready <= 1'b0;
      end else if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
        // long enough to fill the whole pipeline and push back on the input
        long_hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES - 1) @(negedge clk_i);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold_len = $urandom_range(1, 3);
        m_axis_tready <= 1'b0;
        repeat (hold_len - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // compare every result beat with the oldest waiting verdict
  always @(posedge clk_i) begin : result_check
    contact_t got;
    contact_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.hit = m_axis_tdata[0];
      got.sep = m_axis_tdata[32:1];
      got.sat = m_axis_tdata[33];
      if (contact_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual hit %0b sep %0d sat %0b",
                 $time, got.hit, got.sep, got.sat);
        errors++;
      end else begin
        want = contact_q.pop_front();
        if (got.hit !== want.hit) begin
          $display("%0t: result %0d hit expected %0b actual %0b",
                   $time, results_seen, want.hit, got.hit);
          errors++;
        end
        if (got.sep !== want.sep) begin
          $display("%0t: result %0d separation expected %0d actual %0d",
                   $time, results_seen, want.sep, got.sep);
          errors++;
        end
        if (got.sat !== want.sat) begin
          $display("%0t: result %0d saturated expected %0b actual %0b",
                   $time, results_seen, want.sat, got.sat);
          errors++;
        end
      end
      results_seen++;
    end
  end

  initial begin : stimulus
    sphere_pair_t p;
    logic         kind;
    logic [31:0]  sx, sy, sz, ox, oy, oz;
    logic [30:0]  s_rad, o_rad;
    logic [31:0]  span_mask;
    logic [31:0]  delta;
    int unsigned  shape;
    int unsigned  span;

    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;

    // all zero: coincident points of no size
    add_row(make_pair(KIND_SPHERES, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 32'h0, 0);
    // unsupported pair with every field at an extreme
    add_row(make_pair(KIND_UNSUPPORTED, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      31'h7FFF_FFFF), 1, 0, 32'h0, 0);
    // widest spread on all axes, no radii: clamps high
    add_row(make_pair(KIND_SPHERES, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0),
            1, 0, 32'h7FFF_FFFF, 1);
    // same with largest radii, still clamps high
    add_row(make_pair(KIND_SPHERES, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      31'h7FFF_FFFF), 1, 0, 32'h7FFF_FFFF, 1);
    // same center, largest radii: clamps low
    add_row(make_pair(KIND_SPHERES, 0, 0, 0, 31'h7FFF_FFFF, 0, 0, 0, 31'h7FFF_FFFF),
            1, 1, 32'h8000_0000, 1);
    // both centers at the top corner
    add_row(make_pair(KIND_SPHERES, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0), 1, 0, 32'h0, 0);
    // exact touch along x is not a hit
    add_row(make_pair(KIND_SPHERES, 0, 0, 0, 31'h8000, 32'h0001_0000, 0, 0, 31'h8000),
            1, 0, 32'h0, 0);
    // overlap by one lsb
    add_row(make_pair(KIND_SPHERES, 0, 0, 0, 31'h8001, 32'h0001_0000, 0, 0, 31'h8000),
            1, 1, 32'hFFFF_FFFF, 0);
    // separation lands exactly on the top of the range
    add_row(make_pair(KIND_SPHERES, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 0),
            1, 0, 32'h7FFF_FFFF, 0);
    // one past the top
    add_row(make_pair(KIND_SPHERES, 0, 0, 0, 0, 32'h8000_0000, 0, 0, 0),
            1, 0, 32'h7FFF_FFFF, 1);
    // separation lands exactly on the bottom of the range
    add_row(make_pair(KIND_SPHERES, 0, 0, 0, 31'h4000_0000, 0, 0, 0, 31'h4000_0000),
            1, 1, 32'h8000_0000, 0);
    // one past the bottom
    add_row(make_pair(KIND_SPHERES, 0, 0, 0, 31'h4000_0000, 0, 0, 0, 31'h4000_0001),
            1, 1, 32'h8000_0000, 1);
    // exact touch along negative y
    add_row(make_pair(KIND_SPHERES, 0, 0, 0, 31'h8000, 0, 32'hFFFF_0000, 0, 31'h8000),
            1, 0, 32'h0, 0);
    // gap of one unit along z
    add_row(make_pair(KIND_SPHERES, 0, 0, 32'h0003_0000, 31'h1_0000, 0, 0, 0, 31'h1_0000),
            1, 0, 32'h0001_0000, 0);
    // 3-4-5 triangle, exact touch
    add_row(make_pair(KIND_SPHERES, 0, 0, 0, 31'h2_0000, 32'h0003_0000, 32'h0004_0000, 0,
                      31'h3_0000), 1, 0, 32'h0, 0);
    // irrational distance, root rounds down
    add_row(make_pair(KIND_SPHERES, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000,
                      32'h0001_0000, 0), 0, 0, 32'h0, 0);
    // one lsb apart
    add_row(make_pair(KIND_SPHERES, 0, 0, 0, 0, 32'h1, 0, 0, 0), 1, 0, 32'h1, 0);
    // sqrt of two lsb squared
    add_row(make_pair(KIND_SPHERES, 0, 0, 0, 0, 32'h1, 32'h1, 0, 0), 0, 0, 32'h0, 0);
    // unsupported pair, all zero
    add_row(make_pair(KIND_UNSUPPORTED, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 32'h0, 0);
    // mixed signs and patterns
    add_row(make_pair(KIND_SPHERES, 32'h1234_5678, 32'hFEDC_BA98, 32'h0F0F_0F0F,
                      31'h2AAA_AAAA, 32'hF0F0_F0F0, 32'h0123_4567, 32'h8000_0001,
                      31'h5555_5555), 0, 0, 32'h0, 0);
    // full x spread against largest radii, just apart
    add_row(make_pair(KIND_SPHERES, 32'h8000_0000, 0, 0, 31'h7FFF_FFFF,
                      32'h7FFF_FFFF, 0, 0, 31'h7FFF_FFFF), 1, 0, 32'h1, 0);
    // one radius at max, the other zero, same center
    add_row(make_pair(KIND_SPHERES, 0, 0, 0, 31'h7FFF_FFFF, 0, 0, 0, 0),
            1, 1, 32'h8000_0001, 0);

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[k])
      send_pair(directed_rows[k].pair, directed_rows[k].typed, directed_rows[k].want);

    for (int unsigned n = 0; n < RANDOM_PAIRS; n++) begin
      calm  = (n >= RANDOM_PAIRS - CALM_TAIL);
      shape = $urandom_range(0, 9);
      kind  = KIND_SPHERES;
      sx = $urandom;
      sy = $urandom;
      sz = $urandom;
      ox = $urandom;
      oy = $urandom;
      oz = $urandom;
      s_rad = 31'($urandom);
      o_rad = 31'($urandom);
      if (shape <= 4) begin
        // nearby spheres at a random scale, so hits and misses both show up
        span = $urandom_range(0, 26);
        span_mask = (32'd1 << span) - 1;
        delta = $urandom & span_mask;
        ox = sx + ($urandom_range(0, 1) ? -delta : delta);
        delta = $urandom & span_mask;
        oy = sy + ($urandom_range(0, 1) ? -delta : delta);
        delta = $urandom & span_mask;
        oz = sz + ($urandom_range(0, 1) ? -delta : delta);
        s_rad = 31'($urandom & ((span_mask << 1) | 1));
        o_rad = 31'($urandom & ((span_mask << 1) | 1));
      end else if (shape == 5) begin
        ox = sx;
        oy = sy;
        oz = sz;
      end else if (shape == 9) begin
        kind = KIND_UNSUPPORTED;
      end
      p = make_pair(kind, sx, sy, sz, s_rad, ox, oy, oz, o_rad);
      send_pair(p, 1'b0, '0);
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    wait (contact_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
